// File: sv/md5_pkg.sv
// MD5 package: payload structs, round tables, initial chaining values.
// No dependencies.
package md5_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       is_last;
    } in_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [1:0]  word_index;
        logic        last_word;
    } out_item_t;

    // queue entry from front to back: one message byte, an end marker, or both
    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       is_last;
    } cmd_t;

    localparam int QueueDepthDefault = 4;

    localparam logic [31:0] InitA = 32'h67452301;
    localparam logic [31:0] InitB = 32'hefcdab89;
    localparam logic [31:0] InitC = 32'h98badcfe;
    localparam logic [31:0] InitD = 32'h10325476;
    localparam logic [7:0]  PadByte = 8'h80;
    localparam int          BlockBytes = 512 / 8;
    localparam int          LenPos = 448 / 8;

    function automatic logic [31:0] sine_k(input logic [5:0] n);
        logic [31:0] k;
        unique case (n)
            6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;
            6'd2: k = 32'h242070db;  6'd3: k = 32'hc1bdceee;
            6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
            6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;
            6'd8: k = 32'h698098d8;  6'd9: k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb; 6'd63: k = 32'heb86d391;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] shift_r(input logic [5:0] n);
        logic [4:0] s;
        unique case ({n[5:4], n[1:0]})
            4'b0000: s = 5'd7;  4'b0001: s = 5'd12; 4'b0010: s = 5'd17; 4'b0011: s = 5'd22;
            4'b0100: s = 5'd5;  4'b0101: s = 5'd9;  4'b0110: s = 5'd14; 4'b0111: s = 5'd20;
            4'b1000: s = 5'd4;  4'b1001: s = 5'd11; 4'b1010: s = 5'd16; 4'b1011: s = 5'd23;
            4'b1100: s = 5'd6;  4'b1101: s = 5'd10; 4'b1110: s = 5'd15; 4'b1111: s = 5'd21;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

    // message word index used by round n
    function automatic logic [3:0] word_pick(input logic [5:0] n);
        logic [3:0] p;
        logic [3:0] m;
        m = n[3:0];
        unique case (n[5:4])
            2'd0: p = m;
            2'd1: p = 4'((m << 2) + m + 4'd1);
            2'd2: p = 4'((m << 1) + m + 4'd5);
            2'd3: p = 4'((m << 3) - m);
            default: p = m;
        endcase
        return p;
    endfunction

endpackage

// File: sv/md5_cmd_queue.sv
// Short queue of byte/end commands between the front and back parts.
// Depends on md5_pkg.
module md5_cmd_queue #(
    parameter int DEPTH = md5_pkg::QueueDepthDefault
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  md5_pkg::cmd_t wr_data,
    output logic          full,
    input  logic          rd_en,
    output md5_pkg::cmd_t rd_data,
    output logic          empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    md5_pkg::cmd_t      mem_reg [DEPTH];
    logic [AW-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]        count_reg;

    assign full    = (count_reg == (AW+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en && !full)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en && !full)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (rd_en && !empty)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + (AW+1)'(wr_en && !full) - (AW+1)'(rd_en && !empty);
        end
    end
endmodule

// File: sv/md5_core.sv
// Back part: block buffer, padding sequencer, one MD5 round per cycle,
// digest word output register. Depends on md5_pkg.
module md5_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    input  md5_pkg::cmd_t      cmd,
    output logic               cmd_pop,
    output logic               empty,
    input  logic               pop,
    output md5_pkg::out_item_t result
);
    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_PAD   = 6'b000010,
        ST_LEN   = 6'b000100,
        ST_ROUND = 6'b001000,
        ST_ADD   = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;

    state_t       state_reg;
    logic [31:0]  buf_reg [md5_pkg::BlockBytes / 4];
    logic [60:0]  count_reg;
    logic [5:0]   pos_reg;
    logic [5:0]   round_reg;
    logic         ext_reg;
    logic         done_reg;
    logic         bdone_reg;
    logic [31:0]  ca_reg, cb_reg, cc_reg, cd_reg;
    logic [31:0]  wa_reg, wb_reg, wc_reg, wd_reg;
    logic [31:0]  kw_reg;
    logic [1:0]   oidx_reg;
    logic         ovalid_reg;
    logic [63:0]  bits;
    logic [31:0]  mix, sum, rot, kw_next;
    logic [5:0]   round_nx;
    logic [4:0]   sh;
    logic         take_byte;
    logic         wr_en;
    logic [7:0]   wr_byte;

    assign bits      = {count_reg, 3'b000};
    assign sh        = md5_pkg::shift_r(round_reg);
    // a last item with a byte is handled in two steps: byte, then end marker
    assign take_byte = cmd.has_byte && !bdone_reg;
    // constant plus message word, registered in the cycle before its round
    assign round_nx  = (state_reg == ST_ROUND) ? round_reg + 6'd1 : 6'd0;
    assign kw_next   = md5_pkg::sine_k(round_nx) + buf_reg[md5_pkg::word_pick(round_nx)];

    always_comb
    begin
        unique case (round_reg[5:4])
            2'd0: mix = (wb_reg & wc_reg) | (~wb_reg & wd_reg);
            2'd1: mix = (wd_reg & wb_reg) | (~wd_reg & wc_reg);
            2'd2: mix = wb_reg ^ wc_reg ^ wd_reg;
            2'd3: mix = wc_reg ^ (wb_reg | ~wd_reg);
            default: mix = '0;
        endcase
        sum = wa_reg + mix + kw_reg;
        rot = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));
    end

    assign cmd_pop = (state_reg == ST_IDLE) && cmd_valid && !(take_byte && cmd.is_last);
    assign empty   = !ovalid_reg;

    always_comb
    begin
        unique case (oidx_reg)
            2'd0: result.digest_word = ca_reg;
            2'd1: result.digest_word = cb_reg;
            2'd2: result.digest_word = cc_reg;
            2'd3: result.digest_word = cd_reg;
            default: result.digest_word = ca_reg;
        endcase
        result.word_index = oidx_reg;
        result.last_word  = (oidx_reg == 2'd3);
    end

    // buffer write port
    always_comb
    begin
        wr_en   = 1'b0;
        wr_byte = 8'h00;
        unique case (state_reg)
            ST_IDLE:
            begin
                wr_en   = cmd_valid;
                wr_byte = take_byte ? cmd.data_byte : md5_pkg::PadByte;
            end
            ST_PAD:
            begin
                wr_en   = 1'b1;
                wr_byte = 8'h00;
            end
            ST_LEN:
            begin
                wr_en   = 1'b1;
                wr_byte = bits[{pos_reg[2:0], 3'b000} +: 8];
            end
            default:
            begin
                wr_en   = 1'b0;
                wr_byte = 8'h00;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            buf_reg[pos_reg[5:2]][{pos_reg[1:0], 3'b000} +: 8] <= wr_byte;
        end
    end

    // ext_reg: padding spills into a second block
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            pos_reg    <= '0;
            round_reg  <= '0;
            ext_reg    <= 1'b0;
            done_reg   <= 1'b0;
            bdone_reg  <= 1'b0;
            ca_reg     <= md5_pkg::InitA;
            cb_reg     <= md5_pkg::InitB;
            cc_reg     <= md5_pkg::InitC;
            cd_reg     <= md5_pkg::InitD;
            oidx_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        pos_reg <= pos_reg + 6'd1;
                        if (take_byte)
                        begin
                            count_reg <= count_reg + 61'd1;
                            bdone_reg <= cmd.is_last;
                            if (pos_reg == 6'd63)
                            begin
                                state_reg <= ST_ROUND;
                            end
                        end
                        else
                        begin
                            // end marker written at pos
                            bdone_reg <= 1'b0;
                            ext_reg   <= (pos_reg >= 6'(md5_pkg::LenPos));
                            if (pos_reg == 6'd63)
                            begin
                                state_reg <= ST_ROUND;
                            end
                            else if (pos_reg == 6'(md5_pkg::LenPos - 1))
                            begin
                                state_reg <= ST_LEN;
                            end
                            else
                            begin
                                state_reg <= ST_PAD;
                            end
                        end
                    end
                end
                ST_PAD:
                begin
                    pos_reg <= pos_reg + 6'd1;
                    if (pos_reg == 6'(md5_pkg::LenPos - 1))
                    begin
                        state_reg <= ST_LEN;
                    end
                    else if (pos_reg == 6'd63)
                    begin
                        state_reg <= ST_ROUND;
                    end
                end
                ST_LEN:
                begin
                    pos_reg <= pos_reg + 6'd1;
                    if (pos_reg == 6'd63)
                    begin
                        state_reg <= ST_ROUND;
                        done_reg  <= 1'b1;
                    end
                end
                ST_ROUND:
                begin
                    round_reg <= round_reg + 6'd1;
                    if (round_reg == 6'd63)
                    begin
                        state_reg <= ST_ADD;
                    end
                end
                ST_ADD:
                begin
                    ca_reg <= ca_reg + wa_reg;
                    cb_reg <= cb_reg + wb_reg;
                    cc_reg <= cc_reg + wc_reg;
                    cd_reg <= cd_reg + wd_reg;
                    if (done_reg)
                    begin
                        state_reg  <= ST_OUT;
                        oidx_reg   <= 2'd0;
                        ovalid_reg <= 1'b1;
                    end
                    else if (ext_reg)
                    begin
                        ext_reg   <= 1'b0;
                        state_reg <= ST_PAD;
                    end
                    else
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_OUT:
                begin
                    if (pop && ovalid_reg)
                    begin
                        oidx_reg <= oidx_reg + 2'd1;
                        if (oidx_reg == 2'd3)
                        begin
                            ovalid_reg <= 1'b0;
                            state_reg  <= ST_IDLE;
                            ca_reg     <= md5_pkg::InitA;
                            cb_reg     <= md5_pkg::InitB;
                            cc_reg     <= md5_pkg::InitC;
                            cd_reg     <= md5_pkg::InitD;
                            count_reg  <= '0;
                            pos_reg    <= '0;
                            done_reg   <= 1'b0;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // working words
    always_ff @(posedge clk)
    begin
        kw_reg <= kw_next;
        if (state_reg == ST_ROUND)
        begin
            wa_reg <= wd_reg;
            wb_reg <= wb_reg + rot;
            wc_reg <= wb_reg;
            wd_reg <= wc_reg;
        end
        else
        begin
            wa_reg <= ca_reg;
            wb_reg <= cb_reg;
            wc_reg <= cc_reg;
            wd_reg <= cd_reg;
        end
    end
endmodule

// File: sv/md5_front.sv
// Front part: accepts input transfers, drops items that do nothing,
// and pushes byte/end commands into the queue. Depends on md5_pkg.
module md5_front (
    input  logic              push,
    input  md5_pkg::in_item_t in_item,
    output logic              full,
    output logic              q_wr,
    output md5_pkg::cmd_t     q_data,
    input  logic              q_full
);
    assign full = q_full;
    assign q_wr = push && !q_full && (in_item.has_byte || in_item.is_last);
    assign q_data.data_byte = in_item.data_byte;
    assign q_data.has_byte  = in_item.has_byte;
    assign q_data.is_last   = in_item.is_last;
endmodule

// File: sv/md5_message_digest.sv
// MD5 message digest top level: front, command queue, back core.
// Depends on md5_pkg, md5_front, md5_cmd_queue, md5_core.
// Bytes enter one per transfer into a short queue; the core takes one
// byte per cycle into the block buffer while idle with the queue not
// empty. A full block then passes through the round and add states,
// during which the queue absorbs input until full. A last item adds an
// end marker (after its byte, if it has one), padding and one or two
// block compressions, then four digest words leave by pop.
module md5_message_digest #(
    parameter int QUEUE_DEPTH = md5_pkg::QueueDepthDefault
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  md5_pkg::in_item_t  in_item,
    output logic               full,
    output logic               empty,
    input  logic               pop,
    output md5_pkg::out_item_t out_item
);
    logic          q_wr, q_full, q_empty, q_pop;
    md5_pkg::cmd_t q_wdata, q_rdata;

    md5_front u_front (
        .push, .in_item, .full,
        .q_wr, .q_data(q_wdata), .q_full
    );

    md5_cmd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk, .rst_n, .wr_en(q_wr), .wr_data(q_wdata), .full(q_full),
        .rd_en(q_pop), .rd_data(q_rdata), .empty(q_empty)
    );

    md5_core u_core (
        .clk, .rst_n, .cmd_valid(!q_empty), .cmd(q_rdata), .cmd_pop(q_pop),
        .empty, .pop, .result(out_item)
    );
endmodule

// File: sv/md5_message_digest_checker.sv
// Port-level checker for md5_message_digest, bound to the top level.
// Depends on md5_pkg.
module md5_message_digest_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               empty,
    input logic               pop,
    input md5_pkg::out_item_t out_item
);
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (out_item.last_word == (out_item.word_index == 2'd3)))
        else $error("last_word mismatch");

    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && out_item.word_index != 2'd3) |=>
        (!empty && out_item.word_index == $past(out_item.word_index) + 2'd1))
        else $error("digest words not consecutive");

    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(out_item)))
        else $error("result changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(empty) |-> out_item.word_index == 2'd0)
        else $error("digest not starting at word 0");
endmodule

bind md5_message_digest md5_message_digest_checker u_checker (
    .clk, .rst_n, .empty, .pop, .out_item
);
